FILE: src/egop_pkg.sv
// ----------------------------------------------------------------------------
// egop_pkg
// Shared types and constants of the 3x3 edge gradient operator.
// ----------------------------------------------------------------------------
package egop_pkg;

    localparam int PIX_BITS  = 8;
    localparam int ROW_BITS  = 12;
    localparam int OCOL_BITS = 10;
    localparam int TERM_BITS = 12;
    localparam int MODE_BITS = 2;
    localparam int WREG_BITS = 11;
    localparam int HREG_BITS = 13;
    localparam int CFG_BITS  = 13;
    localparam int IDX_BITS  = 2;

    localparam logic [WREG_BITS-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [HREG_BITS-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [HREG_BITS-1:0] HEIGHT_MAX   = 13'd4096;
    localparam int                   MIN_DIM      = 3;

    localparam logic [IDX_BITS-1:0] CFG_MODE   = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_DIFF    = 2'd0,
        MODE_ROBERTS = 2'd1,
        MODE_SOBEL   = 2'd2,
        MODE_LAPLACE = 2'd3
    } t_mode;

    typedef logic [PIX_BITS-1:0]         t_pix;
    typedef t_pix [2:0]                  t_column;
    typedef logic signed [TERM_BITS-1:0] t_term;

    typedef struct packed {
        logic [ROW_BITS-1:0]  row;
        logic [OCOL_BITS-1:0] col;
        logic                 border;
        logic                 last;
    } t_meta;

endpackage

FILE: src/egop_ram.sv
// ----------------------------------------------------------------------------
// egop_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module egop_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/egop_cell.sv
// ----------------------------------------------------------------------------
// egop_cell
// One window column of three pixels that passes its column to the next cell.
// ----------------------------------------------------------------------------
module egop_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  egop_pkg::t_column i_column,
    output egop_pkg::t_column o_column
);

    egop_pkg::t_column r_column;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
        end else if (i_shift) begin
            r_column <= i_column;
        end
    end

    assign o_column = r_column;

endmodule

FILE: src/egop_kernel.sv
// ----------------------------------------------------------------------------
// egop_kernel
// Signed gradient terms of the 3x3 window for the selected operator.
// ----------------------------------------------------------------------------
module egop_kernel (
    input  egop_pkg::t_column i_left,
    input  egop_pkg::t_column i_mid,
    input  egop_pkg::t_column i_right,
    input  egop_pkg::t_mode   i_mode,
    input  logic              i_border,
    output egop_pkg::t_term   o_term1,
    output egop_pkg::t_term   o_term2,
    output logic              o_laplace
);

    egop_pkg::t_term a, b, c, d, e, f, g, h, i;
    egop_pkg::t_term sx, sy, lap;

    assign a = egop_pkg::t_term'({4'd0, i_left[0]});
    assign b = egop_pkg::t_term'({4'd0, i_mid[0]});
    assign c = egop_pkg::t_term'({4'd0, i_right[0]});
    assign d = egop_pkg::t_term'({4'd0, i_left[1]});
    assign e = egop_pkg::t_term'({4'd0, i_mid[1]});
    assign f = egop_pkg::t_term'({4'd0, i_right[1]});
    assign g = egop_pkg::t_term'({4'd0, i_left[2]});
    assign h = egop_pkg::t_term'({4'd0, i_mid[2]});
    assign i = egop_pkg::t_term'({4'd0, i_right[2]});

    assign sx  = ((f - d) <<< 1) + (i - g) + (c - a);
    assign sy  = ((b - h) <<< 1) + (c - i) + (a - g);
    assign lap = b + h + d + f - (e <<< 2);

    always_comb begin
        o_term1   = '0;
        o_term2   = '0;
        o_laplace = 1'b0;
        case (i_mode)
            egop_pkg::MODE_DIFF: begin
                o_term1 = e - f;
                o_term2 = h - e;
            end
            egop_pkg::MODE_ROBERTS: begin
                o_term1 = e - i;
                o_term2 = h - f;
            end
            egop_pkg::MODE_SOBEL: begin
                if (!i_border) begin
                    o_term1 = sx;
                    o_term2 = sy;
                end
            end
            egop_pkg::MODE_LAPLACE: begin
                o_laplace = 1'b1;
                if (!i_border) begin
                    o_term1 = lap;
                end
            end
            default: begin
                o_term1 = '0;
            end
        endcase
    end

endmodule

FILE: src/edge_gradient_operator_3x3.sv
// ----------------------------------------------------------------------------
// edge_gradient_operator_3x3
// Raster-stream 3x3 edge operator with two line stores and a window chain.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents (lowest bits first)
// s_axis    in         tdata: pixel[7:0]
// m_axis    out        tdata: edge_value[7:0], out_row[19:8], out_col[29:20];
//                      tlast: frame_last
// cfg       in         index 0 mode, 1 image_width, 2 image_height
//
// One pixel is taken in every cycle while the stages have room. A result is
// offered behind the input register, window cells, term and output registers.
// Reset clears the counters, the window and the valid flags; the line stores
// hold no reset state and need no clearing pass.
// The input side keeps taking beats while a result waits, until all four
// internal stages are full.
// ----------------------------------------------------------------------------
module edge_gradient_operator_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // pixel
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [31:0]                   o_m_axis_tdata,   // edge_value, out_row, out_col
    output logic                          o_m_axis_tlast,   // frame_last
    input  logic                          i_cfg_wen,
    input  logic [egop_pkg::IDX_BITS-1:0] i_cfg_addr,
    input  logic [egop_pkg::CFG_BITS-1:0] i_cfg_wdata
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > egop_pkg::WREG_BITS) ?
                         $clog2(MAX_WIDTH + 1) : egop_pkg::WREG_BITS;
    localparam int RW  = 2 * egop_pkg::PIX_BITS;
    localparam int HW  = egop_pkg::HREG_BITS;

    egop_pkg::t_mode                   r_mode;
    logic [egop_pkg::WREG_BITS-1:0]    r_width;
    logic [HW-1:0]                     r_height;

    logic [CW-1:0]                     r_col;
    logic [egop_pkg::ROW_BITS-1:0]     r_row;

    logic                              r_v1, r_emit1;
    egop_pkg::t_pix                    r_px1;
    logic [CW-1:0]                     r_col1;
    egop_pkg::t_meta                   r_meta1;
    logic                              r_v2;
    egop_pkg::t_meta                   r_meta2;
    logic                              r_v3, r_lap3;
    egop_pkg::t_term                   r_t1, r_t2;
    egop_pkg::t_meta                   r_meta3;
    logic                              r_ov;
    egop_pkg::t_pix                    r_edge;
    egop_pkg::t_meta                   r_meta_o;

    logic                              en_out, en3, en2, en1, accept, shift;
    logic [WCW-1:0]                    w_eff, w_reg, col_p1, col_w;
    logic [HW-1:0]                     h_eff, row_p1;
    logic                              col_end, row_end;
    logic [CW-1:0]                     n_col;
    logic [egop_pkg::ROW_BITS-1:0]     n_row;
    egop_pkg::t_meta                   n_meta;
    logic [RW-1:0]                     ram_rdata;
    egop_pkg::t_column                 col_new, col_c2, col_c1, col_c0;
    egop_pkg::t_term                   k_t1, k_t2;
    logic                              k_lap;
    egop_pkg::t_term                   abs1, abs2;
    logic [egop_pkg::TERM_BITS-1:0]    mag;
    egop_pkg::t_pix                    n_edge;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= egop_pkg::MODE_DIFF;
            r_width  <= egop_pkg::WIDTH_RESET;
            r_height <= egop_pkg::HEIGHT_RESET;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                egop_pkg::CFG_MODE:   r_mode   <= egop_pkg::t_mode'(i_cfg_wdata[1:0]);
                egop_pkg::CFG_WIDTH:  r_width  <= i_cfg_wdata[egop_pkg::WREG_BITS-1:0];
                egop_pkg::CFG_HEIGHT: r_height <= i_cfg_wdata[HW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline handshake.
    assign en_out          = !r_ov || i_m_axis_tready;
    assign en3             = !r_v3 || en_out;
    assign en2             = !r_v2 || en3;
    assign en1             = !r_v1 || en2;
    assign accept          = i_s_axis_tvalid && en1;
    assign shift           = r_v1 && en2;
    assign o_s_axis_tready = en1;

    // Raster position.
    always_comb begin
        w_reg = WCW'(r_width);
        if (w_reg < WCW'(egop_pkg::MIN_DIM)) begin
            w_eff = WCW'(egop_pkg::MIN_DIM);
        end else if (w_reg > WCW'(MAX_WIDTH)) begin
            w_eff = WCW'(MAX_WIDTH);
        end else begin
            w_eff = w_reg;
        end
        if (r_height < HW'(egop_pkg::MIN_DIM)) begin
            h_eff = HW'(egop_pkg::MIN_DIM);
        end else if (r_height > egop_pkg::HEIGHT_MAX) begin
            h_eff = egop_pkg::HEIGHT_MAX;
        end else begin
            h_eff = r_height;
        end
        col_w   = WCW'(r_col);
        col_p1  = col_w + WCW'(1);
        row_p1  = HW'(r_row) + HW'(1);
        col_end = col_p1 >= w_eff;
        row_end = row_p1 >= h_eff;
        n_col   = col_end ? '0 : r_col + CW'(1);
        n_row   = r_row;
        if (col_end) begin
            n_row = row_end ? '0 : r_row + egop_pkg::ROW_BITS'(1);
        end
        n_meta.row    = r_row - egop_pkg::ROW_BITS'(1);
        n_meta.col    = egop_pkg::OCOL_BITS'(col_w - WCW'(1));
        n_meta.border = (r_row == egop_pkg::ROW_BITS'(1)) || (r_col == CW'(1));
        n_meta.last   = row_end && col_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Line stores: upper byte holds the row two above, lower byte the row above.
    egop_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (shift),
        .i_waddr (r_col1),
        .i_wdata ({ram_rdata[egop_pkg::PIX_BITS-1:0], r_px1}),
        .i_re    (accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px1   <= i_s_axis_tdata;
            r_col1  <= r_col;
            r_meta1 <= n_meta;
            r_emit1 <= (r_row != '0) && (r_col != '0);
        end
    end

    // Window chain, newest column on the right.
    assign col_new[0] = ram_rdata[RW-1:egop_pkg::PIX_BITS];
    assign col_new[1] = ram_rdata[egop_pkg::PIX_BITS-1:0];
    assign col_new[2] = r_px1;

    egop_cell u_cell_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (shift),
        .i_column (col_new),
        .o_column (col_c2)
    );

    egop_cell u_cell_mid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (shift),
        .i_column (col_c2),
        .o_column (col_c1)
    );

    egop_cell u_cell_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (shift),
        .i_column (col_c1),
        .o_column (col_c0)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1 && r_emit1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_meta2 <= r_meta1;
        end
    end

    egop_kernel u_kernel (
        .i_left    (col_c0),
        .i_mid     (col_c1),
        .i_right   (col_c2),
        .i_mode    (r_mode),
        .i_border  (r_meta2.border),
        .o_term1   (k_t1),
        .o_term2   (k_t2),
        .o_laplace (k_lap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_t1    <= k_t1;
            r_t2    <= k_t2;
            r_lap3  <= k_lap;
            r_meta3 <= r_meta2;
        end
    end

    // Magnitude and clamp.
    always_comb begin
        abs1 = r_t1[egop_pkg::TERM_BITS-1] ? -r_t1 : r_t1;
        abs2 = r_t2[egop_pkg::TERM_BITS-1] ? -r_t2 : r_t2;
        mag  = r_lap3 ? r_t1 : abs1 + abs2;
        if (r_lap3 && r_t1[egop_pkg::TERM_BITS-1]) begin
            n_edge = '0;
        end else if (mag[egop_pkg::TERM_BITS-1:egop_pkg::PIX_BITS] != '0) begin
            n_edge = '1;
        end else begin
            n_edge = mag[egop_pkg::PIX_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && r_v3) begin
            r_edge   <= n_edge;
            r_meta_o <= r_meta3;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {2'b00, r_meta_o.col, r_meta_o.row, r_edge};
    assign o_m_axis_tlast  = r_meta_o.last;

`ifndef NO_ASSERTIONS
    a_stall_only_from_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without a blocked result");

    a_line_store_no_collide : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (shift && accept) |-> (r_col1 != r_col))
        else $error("line store write and read hit the same column");

    a_result_from_stage : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_v3))
        else $error("result appeared without a computed item");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 edge gradient operator. Pixel frames are
// streamed under random source and sink gaps, every result beat is checked
// against a cycle-free model of the line stores and window, and the image
// size and operator are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_W         = 1024;
    localparam int ROWS_MAX      = int'(egop_pkg::HEIGHT_MAX);
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int LOG_LIMIT     = 10;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_BUDGET = 360;

    localparam logic [8:0][7:0] SOBEL_FRAME = {
        8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00
    };
    localparam logic [11:0][7:0] LAPLACE_FRAME = {
        8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF,
        8'h00, 8'h00, 8'hFF, 8'h00
    };

    typedef struct packed {
        logic [7:0]                     magnitude;
        logic [egop_pkg::ROW_BITS-1:0]  row;
        logic [egop_pkg::OCOL_BITS-1:0] col;
        logic                           last;
    } t_edge_result;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          src_valid = 1'b0;
    logic [7:0]                    src_pixel = '0;
    logic                          sink_ready = 1'b0;
    logic                          cfg_wen   = 1'b0;
    logic [egop_pkg::IDX_BITS-1:0] cfg_addr  = '0;
    logic [egop_pkg::CFG_BITS-1:0] cfg_wdata = '0;
    logic                          s_tready;
    logic                          m_tvalid;
    logic [31:0]                   m_tdata;
    logic                          m_tlast;

    // Operator state mirrored from the block.
    logic [7:0]      line_prev  [MAX_W];
    logic [7:0]      line_prev2 [MAX_W];
    logic [7:0]      win [3][3];
    int unsigned     row_cnt;
    int unsigned     col_cnt;
    egop_pkg::t_mode op_mode;
    int unsigned     reg_width;
    int unsigned     reg_height;

    logic [7:0]   pixel_backlog[$];
    t_edge_result pending_results[$];
    int           pixels_unsent   = 0;
    int           pixels_sent     = 0;
    int           results_checked = 0;
    int           frames_done     = 0;
    int           mismatches      = 0;
    int           cycle_count     = 0;

    int src_gap     = 0;
    int src_streak  = 0;
    bit src_calm    = 1'b0;
    int src_draw;
    int sink_wait   = 0;
    int sink_streak = 0;
    bit sink_calm   = 1'b0;
    int sink_draw;
    bit long_hold_done = 1'b0;
    t_edge_result got;
    t_edge_result want;

    edge_gradient_operator_3x3 #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (src_pixel),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (sink_ready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < egop_pkg::MIN_DIM) return egop_pkg::MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int iabs(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [7:0] operator_value(bit border);
        int a, b, c, d, e, f, g, h, i, acc;
        a = win[0][0]; b = win[0][1]; c = win[0][2];
        d = win[1][0]; e = win[1][1]; f = win[1][2];
        g = win[2][0]; h = win[2][1]; i = win[2][2];
        case (op_mode)
            egop_pkg::MODE_DIFF:    acc = iabs(e - f) + iabs(h - e);
            egop_pkg::MODE_ROBERTS: acc = iabs(e - i) + iabs(h - f);
            egop_pkg::MODE_SOBEL: begin
                acc = border ? 0 : iabs(2 * (f - d) + (i - g) + (c - a))
                                 + iabs(2 * (b - h) + (c - i) + (a - g));
            end
            default:      acc = border ? 0 : b + h + d + f - 4 * e;
        endcase
        if (acc < 0) return 8'd0;
        if (acc > 255) return 8'd255;
        return acc[7:0];
    endfunction

    function automatic void advance_operator(logic [7:0] px);
        int unsigned  w, h;
        int           r;
        logic [7:0]   above, above2;
        t_edge_result res;
        w = clamp_dim(reg_width, MAX_W);
        h = clamp_dim(reg_height, ROWS_MAX);
        above  = line_prev[col_cnt];
        above2 = line_prev2[col_cnt];
        line_prev2[col_cnt] = above;
        line_prev[col_cnt]  = px;
        for (r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = above2;
        win[1][2] = above;
        win[2][2] = px;
        if (row_cnt >= 1 && col_cnt >= 1) begin
            res.row       = egop_pkg::ROW_BITS'(row_cnt - 1);
            res.col       = egop_pkg::OCOL_BITS'(col_cnt - 1);
            res.last      = (row_cnt + 1 >= h) && (col_cnt + 1 >= w);
            res.magnitude = operator_value(row_cnt == 1 || col_cnt == 1);
            pending_results.push_back(res);
        end
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt++;
        end
    endfunction

    function automatic int pixels_to_frame_end();
        int unsigned w, h;
        int          n;
        w = clamp_dim(reg_width, MAX_W);
        h = clamp_dim(reg_height, ROWS_MAX);
        n = (col_cnt + 1 >= w) ? 1 : int'(w - col_cnt);
        if (row_cnt + 1 < h) n += int'((h - row_cnt - 1) * w);
        return n;
    endfunction

    function automatic int draw_wait(inout int streak, inout bit calm);
        if (streak == 0) begin
            streak = $urandom_range(10, 60);
            calm   = ($urandom_range(0, 3) == 0);
        end
        streak--;
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    task automatic write_reg(logic [egop_pkg::IDX_BITS-1:0] idx,
                             logic [egop_pkg::CFG_BITS-1:0] val);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            egop_pkg::CFG_MODE:   op_mode    = egop_pkg::t_mode'(val[egop_pkg::MODE_BITS-1:0]);
            egop_pkg::CFG_WIDTH:  reg_width  = val[egop_pkg::WREG_BITS-1:0];
            egop_pkg::CFG_HEIGHT: reg_height = val[egop_pkg::HREG_BITS-1:0];
            default:    ;
        endcase
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] px);
        pixel_backlog.push_back(px);
        pixels_unsent++;
    endtask

    task automatic queue_pixels(int count, int style);
        logic [7:0] px;
        px = 8'($urandom_range(0, 255));
        repeat (count) begin
            case (style)
                0:       px = 8'($urandom_range(0, 255));
                1:       px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: px = 8'(px + $urandom_range(0, 12) - 6);
            endcase
            send_pixel(px);
        end
    endtask

    task automatic drain();
        while (pixels_unsent != 0 || pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pixel source.
    always @(posedge clk) begin
        if (!rst_n) begin
            src_valid <= 1'b0;
            src_gap = 0;
        end else if (src_valid && s_tready) begin
            advance_operator(src_pixel);
            pixels_unsent--;
            pixels_sent++;
            src_draw = draw_wait(src_streak, src_calm);
            if (src_draw == 0 && pixel_backlog.size() != 0) begin
                src_pixel <= pixel_backlog.pop_front();
            end else begin
                src_valid <= 1'b0;
                src_gap = (src_draw > 0) ? src_draw - 1 : 0;
            end
        end else if (!src_valid) begin
            if (src_gap != 0) begin
                src_gap--;
            end else if (pixel_backlog.size() != 0) begin
                src_valid <= 1'b1;
                src_pixel <= pixel_backlog.pop_front();
            end
        end
    end

    // Result sink and checker.
    always @(posedge clk) begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
            sink_wait = 0;
        end else if (m_tvalid && sink_ready) begin
            got.magnitude = m_tdata[7:0];
            got.row       = m_tdata[19:8];
            got.col       = m_tdata[29:20];
            got.last      = m_tlast;
            if (got.last) frames_done++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= LOG_LIMIT) begin
                    $display("ERROR: unexpected beat: value %0d row %0d col %0d last %0b",
                             got.magnitude, got.row, got.col, got.last);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.magnitude != want.magnitude || got.row != want.row
                        || got.col != want.col || got.last != want.last) begin
                    mismatches++;
                    if (mismatches <= LOG_LIMIT) begin
                        $display("ERROR: want %0d r%0d c%0d l%0b, got %0d r%0d c%0d l%0b",
                                 want.magnitude, want.row, want.col, want.last,
                                 got.magnitude, got.row, got.col, got.last);
                    end
                end
            end
            results_checked++;
            sink_draw = draw_wait(sink_streak, sink_calm);
            if (!long_hold_done && results_checked >= 30 && pixel_backlog.size() > 16) begin
                sink_draw      = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (sink_draw != 0) begin
                sink_ready <= 1'b0;
                sink_wait = sink_draw;
            end
        end else if (!sink_ready) begin
            if (sink_wait <= 1) begin
                sink_ready <= 1'b1;
            end
            sink_wait = (sink_wait > 0) ? sink_wait - 1 : 0;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int          k;
        int          n;
        int          phase;
        int          random_pixels;
        bit          at_start;
        int unsigned new_size;

        for (k = 0; k < MAX_W; k++) begin
            line_prev[k]  = '0;
            line_prev2[k] = '0;
        end
        for (k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
        row_cnt    = 0;
        col_cnt    = 0;
        op_mode    = egop_pkg::MODE_DIFF;
        reg_width  = egop_pkg::WIDTH_RESET;
        reg_height = egop_pkg::HEIGHT_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest frame, sizes written below the minimum, Sobel saturating.
        write_reg(egop_pkg::CFG_MODE, egop_pkg::CFG_BITS'(egop_pkg::MODE_SOBEL));
        write_reg(egop_pkg::CFG_WIDTH, 13'd0);
        write_reg(egop_pkg::CFG_HEIGHT, 13'd2);
        for (k = 0; k < 9; k++) send_pixel(SOBEL_FRAME[k]);
        drain();

        // Laplacian clamped high at one interior position and low at the next.
        write_reg(egop_pkg::CFG_MODE, egop_pkg::CFG_BITS'(egop_pkg::MODE_LAPLACE));
        write_reg(egop_pkg::CFG_WIDTH, 13'd4);
        write_reg(egop_pkg::CFG_HEIGHT, 13'd1);
        for (k = 0; k < 12; k++) send_pixel(LAPLACE_FRAME[k]);
        drain();

        // Mostly whole frames of small random sizes; some phases stop mid-frame
        // so the next one narrows the image or changes the height on the fly.
        phase         = 0;
        random_pixels = 0;
        while (random_pixels < RANDOM_BUDGET) begin
            at_start = (row_cnt == 0 && col_cnt == 0);
            write_reg(egop_pkg::CFG_MODE,
                      egop_pkg::CFG_BITS'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 3)
                                                                      : phase % 4));
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0:       new_size = $urandom_range(0, 2);
                    1:       new_size = $urandom_range(17, 40);
                    default: new_size = $urandom_range(3, 16);
                endcase
                // Widening is only safe where no row above is partly stale.
                if (at_start || clamp_dim(new_size, MAX_W) <= clamp_dim(reg_width, MAX_W)) begin
                    write_reg(egop_pkg::CFG_WIDTH, egop_pkg::CFG_BITS'(new_size));
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                write_reg(egop_pkg::CFG_HEIGHT,
                          egop_pkg::CFG_BITS'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                                          : $urandom_range(3, 8)));
            end
            n = pixels_to_frame_end();
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            queue_pixels(n, $urandom_range(0, 2));
            random_pixels += n;
            phase++;
            drain();
        end

        if (row_cnt != 0 || col_cnt != 0) begin
            queue_pixels(pixels_to_frame_end(), 0);
            drain();
        end

        // Width above the maximum keeps the first row running past any small
        // width, until the width shrinks in the middle of that row.
        write_reg(egop_pkg::CFG_MODE, egop_pkg::CFG_BITS'($urandom_range(0, 3)));
        write_reg(egop_pkg::CFG_WIDTH, 13'h7FF);
        write_reg(egop_pkg::CFG_HEIGHT, 13'd3);
        queue_pixels(20, $urandom_range(0, 2));
        drain();
        write_reg(egop_pkg::CFG_WIDTH, 13'd3);
        queue_pixels(pixels_to_frame_end(), 0);
        drain();

        // Height above the maximum keeps the frame open past three rows, until
        // the height shrinks in the middle of the frame.
        write_reg(egop_pkg::CFG_MODE, egop_pkg::CFG_BITS'($urandom_range(0, 3)));
        write_reg(egop_pkg::CFG_HEIGHT, 13'h1FFF);
        queue_pixels(18, $urandom_range(0, 2));
        drain();
        write_reg(egop_pkg::CFG_HEIGHT, 13'd3);
        queue_pixels(pixels_to_frame_end(), 0);
        drain();

        $display("Streamed %0d pixels and checked %0d results over %0d frames in all four operators.",
                 pixels_sent, results_checked, frames_done);
        $display("Sizes went from the 3x3 minimum to register values past the largest, cut mid-frame.");
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
